// ===== hw/rtl/ssj_pkg.sv =====
// Shared types and constants for the sparse sample hash join core.
`default_nettype none
package ssj_pkg;

  localparam int NCOORD = 4;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_PROBE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  localparam int CFG_MODE_TO_LEAVE = 0;
  localparam int CFG_ACTIVE_MODES  = 1;

  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    logic [31:0] coord_3;
    logic signed [31:0] value;
    logic signed [31:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        matched;
    logic [9:0]  row;
    logic [31:0] col;
    logic signed [63:0] product;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CMP,
    S_ROOT,
    S_MUL,
    S_MUL2,
    S_SCALE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sparse_sample_hash_join_core.sv =====
// Top level of the sparse sample hash join: slot memories, scan sequencer, product unit.
// Each request is taken when start is high and busy is low, and yields exactly one result,
// shown with out_valid for one cycle, starting as busy falls; the receiver cannot stall it,
// and the next request may be taken in that same cycle. A clear, an unknown kind or an
// insert into a full table goes from idle straight to the done state. Inserts and probes
// scan the slot table one slot at a time through the scan, read and compare states (one
// memory read port); a probe that hits then runs a 22-step square root, the two multiply
// states and the scale state before the done state.
// Configuration writes apply at once.
`default_nettype none
module sparse_sample_hash_join_core #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_MODES   = 4,
  parameter int COORD_BITS  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ssj_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output ssj_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [2:0]         cfg_data
);
  import ssj_pkg::*;

  localparam int SW = $clog2(MAX_SAMPLES);
  localparam int CW = SW + 1;
  localparam int KB = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam logic [CW-1:0] MAXS = CW'(MAX_SAMPLES);

  // configuration
  logic [1:0] mode_r;
  logic [2:0] modes_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd0;
      modes_r <= 3'd3;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_MODE_TO_LEAVE)) mode_r <= cfg_data[1:0];
      else modes_r <= cfg_data;
    end
  end

  // slot memories
  logic [4*KB-1:0]  key_mem [MAX_SAMPLES];
  logic [9:0]       idx_mem [MAX_SAMPLES];
  logic [31:0]      wgt_mem [MAX_SAMPLES];
  logic [10:0]      cnt_mem [MAX_SAMPLES];

  state_t     state_r, state_nxt;
  in_item_t   item_r;
  logic [CW-1:0] used_r, next_r, scan_r;
  logic [4*KB-1:0] rkey_r;
  logic [9:0]  ridx_r;
  logic [31:0] rwgt_r;
  logic [10:0] rcnt_r;
  logic [SW-1:0] hit_r;
  // root unit
  logic [43:0] rx_r;
  logic [21:0] rr_r;
  logic [4:0]  rstep_r;
  logic signed [63:0] vw_r;
  logic [63:0] mag_r;
  logic        neg_r;
  logic [85:0] pl_r, ph_r;
  out_item_t   res_r;
  logic        ov_r;

  logic [4*KB-1:0] ikey;
  assign ikey = {in_item.coord_3[KB-1:0], in_item.coord_2[KB-1:0],
                 in_item.coord_1[KB-1:0], in_item.coord_0[KB-1:0]};
  logic [4*KB-1:0] skey;
  assign skey = {item_r.coord_3[KB-1:0], item_r.coord_2[KB-1:0],
                 item_r.coord_1[KB-1:0], item_r.coord_0[KB-1:0]};

  // key compare under current config
  logic [2:0] dim;
  logic [2:0] klen;
  logic       key_eq;
  always_comb begin
    logic [2:0] off;
    dim = modes_r;
    if (MAX_MODES < 4 && dim > 3'(MAX_MODES)) dim = 3'(MAX_MODES);
    if (dim > 3'd4) dim = 3'd4;
    klen = (dim >= 3'd1) ? dim - 3'd1 : 3'd0;
    key_eq = 1'b1;
    for (int j = 0; j < 4; j++) begin
      off = (3'(j) < {1'b0, mode_r}) ? 3'(j) : 3'(j + 1);
      if (3'(j) < klen && off < 3'd4)
        if (rkey_r[off[1:0]*KB +: KB] != skey[off[1:0]*KB +: KB]) key_eq = 1'b0;
    end
  end

  logic start_ok;
  assign start_ok = start && !busy;
  logic scan_end;
  assign scan_end = (scan_r >= used_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start_ok) begin
        if (in_item.kind == KIND_INSERT && next_r >= MAXS) state_nxt = S_DONE;
        else if (in_item.kind == KIND_INSERT || in_item.kind == KIND_PROBE)
          state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_SCAN:  state_nxt = scan_end ? S_DONE : S_READ;
      S_READ:  state_nxt = S_CMP;
      S_CMP: begin
        if (key_eq) state_nxt = (item_r.kind == KIND_PROBE) ? S_ROOT : S_DONE;
        else state_nxt = S_SCAN;
      end
      S_ROOT:  if (rstep_r == 5'd21) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_r != S_IDLE);
    out_valid = ov_r;
    out_item = res_r;
  end

  // memory port: one read, one write per cycle
  logic mem_we;
  logic [SW-1:0] mem_wa;
  logic dup_we;
  assign mem_we = (state_r == S_SCAN) && scan_end && item_r.kind == KIND_INSERT &&
                  used_r < MAXS;
  assign mem_wa = used_r[SW-1:0];
  assign dup_we = (state_r == S_CMP) && key_eq && item_r.kind == KIND_INSERT;
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= skey;
      idx_mem[mem_wa] <= next_r[9:0];
      wgt_mem[mem_wa] <= item_r.weight;
    end
    if (mem_we) cnt_mem[mem_wa] <= 11'd1;
    else if (dup_we && rcnt_r < COUNT_MAX) cnt_mem[hit_r] <= rcnt_r + 11'd1;
    if (state_r == S_SCAN) begin
      rkey_r <= key_mem[scan_r[SW-1:0]];
      ridx_r <= idx_mem[scan_r[SW-1:0]];
      rwgt_r <= wgt_mem[scan_r[SW-1:0]];
      rcnt_r <= cnt_mem[scan_r[SW-1:0]];
    end
  end

  // sequencer datapath
  logic [85:0] qsum;
  assign qsum = ph_r + pl_r;
  always_ff @(posedge clk) begin
    ov_r <= rst_n && (state_r == S_DONE);
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      next_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (start_ok) begin
          item_r <= {in_item.kind, 32'(ikey[0*KB +: KB]), 32'(ikey[1*KB +: KB]),
                     32'(ikey[2*KB +: KB]), 32'(ikey[3*KB +: KB]),
                     in_item.value, in_item.weight};
          scan_r <= '0;
          res_r.status  <= (in_item.kind == KIND_INSERT && next_r >= MAXS) ? ST_FULL : ST_OK;
          res_r.matched <= 1'b0;
          res_r.row     <= '0;
          res_r.col     <= '0;
          res_r.product <= '0;
          if (in_item.kind == KIND_CLEAR) begin
            used_r <= '0;
            next_r <= '0;
          end
        end
        S_SCAN: if (scan_end) begin
          hit_r <= '0;
          if (item_r.kind == KIND_PROBE) res_r.status <= ST_NOMATCH;
          else begin
            if (used_r < MAXS) begin
              res_r.row <= next_r[9:0];
              used_r <= used_r + 1'b1;
            end
            next_r <= next_r + 1'b1;
          end
        end else begin
          hit_r <= scan_r[SW-1:0];
          scan_r <= scan_r + 1'b1;
        end
        S_CMP: if (key_eq) begin
          res_r.row <= ridx_r;
          if (item_r.kind == KIND_INSERT) next_r <= next_r + 1'b1;
          else begin
            res_r.matched <= 1'b1;
            unique case (mode_r)
              2'd0: res_r.col <= item_r.coord_0;
              2'd1: res_r.col <= item_r.coord_1;
              2'd2: res_r.col <= item_r.coord_2;
              default: res_r.col <= item_r.coord_3;
            endcase
            rstep_r <= '0;
            vw_r <= 64'(item_r.value) * 64'(signed'(rwgt_r));
          end
        end
        S_ROOT: begin
          // split sign and magnitude while the root runs
          if (rstep_r == 5'd0) begin
            neg_r <= vw_r[63];
            mag_r <= vw_r[63] ? 64'(0) - vw_r : vw_r;
          end
          rstep_r <= rstep_r + 1'b1;
        end
        S_MUL: begin
          pl_r <= 86'(mag_r[31:0]) * 86'(rr_r);
          ph_r <= 86'(mag_r[63:32]) * 86'(rr_r) << 32;
        end
        S_MUL2: ph_r <= qsum;
        S_SCALE: begin
          if (neg_r) begin
            if ((ph_r >> 32) + 86'(pl_r[31:0] != 0) > 86'(64'h8000_0000_0000))
              res_r.product <= -64'sh8000_0000_0000;
            else res_r.product <= 64'(86'd0 - (ph_r >> 32) - 86'(pl_r[31:0] != 0));
          end else if ((ph_r >> 32) > 86'(64'h7fff_ffff_ffff))
            res_r.product <= 64'sh7fff_ffff_ffff;
          else res_r.product <= 64'(ph_r >> 32);
        end
        default: ;
      endcase
    end
  end

  // square root: one restoring step per cycle, two radicand bits at a time
  logic [23:0] rem_r;
  logic [23:0] rem_t;
  assign rem_t = {rem_r[21:0], rx_r[43:42]};
  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      rem_r <= '0;
      rx_r  <= {1'b0, rcnt_r, 32'd0};
      rr_r  <= '0;
    end else if (state_r == S_ROOT) begin
      rx_r <= rx_r << 2;
      if (rem_t >= {rr_r, 2'b01}) begin
        rem_r <= rem_t - {rr_r, 2'b01};
        rr_r  <= {rr_r[20:0], 1'b1};
      end else begin
        rem_r <= rem_t;
        rr_r  <= {rr_r[20:0], 1'b0};
      end
    end
  end

  // assertions
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result");
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    start_ok |=> busy) else $error("not busy after request");
  a_used_le_next: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= next_r) else $error("slot count exceeds sample count");

endmodule
`default_nettype wire
